>>> hdl/trg_pkg.sv
`default_nettype none

package trg_pkg;

  // Widths of the request and hop fields
  localparam int NodeW     = 8;
  localparam int DimW      = 5;
  localparam int CoordW    = 4;
  localparam int MoveW     = 4;
  localparam int HopIdxW   = 5;
  localparam int CfgIndexW = 2;

  // Grid dimension limits
  localparam int MAX_DIM_DEFAULT = 16;
  localparam int HARD_DIM_CAP    = 16;
  localparam int MAX_MOVES       = HARD_DIM_CAP / 2;

  // Depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes
  localparam logic [CfgIndexW-1:0] CFG_GRID_ROWS = 2'd0;
  localparam logic [CfgIndexW-1:0] CFG_GRID_COLS = 2'd1;

  localparam logic [DimW-1:0] GRID_DIM_RESET = 5'd4;

  typedef struct packed {
    logic [NodeW-1:0] source_node;
    logic [NodeW-1:0] dest_node;
  } trg_req_t;

  typedef struct packed {
    logic [NodeW-1:0]   hop_node;
    logic [HopIdxW-1:0] hop_index;
    logic               last;
    logic               bad_request;
  } trg_hop_t;

  // Planned route handed from front to back
  typedef struct packed {
    logic              bad;
    logic [NodeW-1:0]  src_node;
    logic [CoordW-1:0] cur_row;
    logic [CoordW-1:0] cur_col;
    logic [MoveW-1:0]  col_cnt;
    logic [MoveW-1:0]  row_cnt;
    logic              col_down;
    logic              row_down;
    logic [DimW-1:0]   rows;
    logic [DimW-1:0]   cols;
  } trg_cmd_t;

  // Zero reads as one, anything above cap is clamped to cap
  function automatic logic [DimW-1:0] eff_dim(input logic [DimW-1:0] raw,
                                               input logic [DimW-1:0] cap);
    logic [DimW-1:0] d;
    d = raw;
    if (d == '0) d = DimW'(1);
    if (d > cap) d = cap;
    return d;
  endfunction

endpackage

`default_nettype wire

>>> hdl/torus_xy_route_generator_top.sv
`default_nettype none

// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+-------------------------------
// in       | input     | in_valid_i / in_ready_o    | in_req_i  (source, dest node)
// out      | output    | out_valid_o / out_ready_i  | out_hop_o (node, index, last, bad)
// cfg      | input     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// Front takes a request when idle, divides both nodes by cols (one quotient bit per
// cycle), then pushes the plan into the 2-entry queue, waiting while it is full.
// Out-of-grid requests skip the divider. The back loads a plan only when idle and
// emits one hop per cycle while the output register is free, 1 to 17 hops per route.
// Reset is asynchronous, clears all control state and sets grid rows and cols to 4.
// A stalled output register holds the back; the queue then fills and in_ready_o drops.
module torus_xy_route_generator_top #(
  parameter int MAX_DIM = trg_pkg::MAX_DIM_DEFAULT
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire trg_pkg::trg_req_t             in_req_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output trg_pkg::trg_hop_t                  out_hop_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [trg_pkg::CfgIndexW-1:0] cfg_index_i,
  input  wire logic [trg_pkg::DimW-1:0]      cfg_data_i
);

  logic [trg_pkg::DimW-1:0] grid_rows_q, grid_cols_q;

  logic              cmd_valid, cmd_ready;
  trg_pkg::trg_cmd_t cmd;
  logic              q_valid, q_ready;
  trg_pkg::trg_cmd_t q_cmd;

  // Config writes are always taken; unknown indexes are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= trg_pkg::GRID_DIM_RESET;
      grid_cols_q <= trg_pkg::GRID_DIM_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == trg_pkg::CFG_GRID_ROWS) grid_rows_q <= cfg_data_i;
      if (cfg_index_i == trg_pkg::CFG_GRID_COLS) grid_cols_q <= cfg_data_i;
    end
  end

  // Front: classify the request and plan both rings
  trg_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .grid_rows_i (grid_rows_q),
    .grid_cols_i (grid_cols_q),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // Short queue decouples planning from hop emission
  trg_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_valid),
    .in_ready_o  (cmd_ready),
    .in_cmd_i    (cmd),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_cmd_o   (q_cmd)
  );

  // Back: walk columns then rows, one hop per cycle into the output register when it is free
  trg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (q_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_hop_o   (out_hop_o)
  );

endmodule

`default_nettype wire

>>> hdl/trg_front.sv
`default_nettype none

module trg_front #(
  parameter int MAX_DIM = trg_pkg::MAX_DIM_DEFAULT
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire trg_pkg::trg_req_t          in_req_i,
  input  wire logic [trg_pkg::DimW-1:0]   grid_rows_i,
  input  wire logic [trg_pkg::DimW-1:0]   grid_cols_i,
  output logic                            cmd_valid_o,
  input  wire logic                       cmd_ready_i,
  output trg_pkg::trg_cmd_t               cmd_o
);

  localparam int NodeW  = trg_pkg::NodeW;
  localparam int DimW   = trg_pkg::DimW;
  localparam int CoordW = trg_pkg::CoordW;
  localparam int MoveW  = trg_pkg::MoveW;
  localparam int StepW  = $clog2(NodeW);
  localparam int CapInt = (MAX_DIM < trg_pkg::HARD_DIM_CAP) ? MAX_DIM : trg_pkg::HARD_DIM_CAP;
  localparam logic [DimW-1:0] DimCap = DimW'(CapInt);

  typedef enum logic [1:0] {ST_IDLE, ST_DIVIDE, ST_PUSH} state_e;

  state_e             state_q;
  logic [StepW-1:0]   step_q;
  logic [NodeW-1:0]   src_q;
  logic [NodeW-1:0]   sdiv_q, ddiv_q;
  logic [CoordW-1:0]  srem_q, drem_q;
  logic [DimW-1:0]    rows_q, cols_q;
  logic               bad_q;

  logic [DimW-1:0]    rows_eff, cols_eff;
  logic [2*DimW-1:0]  total_w;
  logic               bad_w;
  logic [CoordW:0]    s_trial, d_trial;
  logic               s_ge, d_ge;
  logic [CoordW-1:0]  s_rem_nx, d_rem_nx;
  logic [MoveW:0]     col_plan, row_plan;
  logic               accept;

  // Pick the shorter way around one ring; tie goes up
  function automatic logic [MoveW:0] plan_dim(input logic [CoordW-1:0] sc,
                                              input logic [CoordW-1:0] dc,
                                              input logic [DimW-1:0]   size);
    logic [DimW:0]   sum;
    logic [DimW-1:0] up;
    logic [DimW-1:0] dn;
    sum = (DimW+1)'(dc) + (DimW+1)'(size) - (DimW+1)'(sc);
    up  = (sum >= {1'b0, size}) ? DimW'(sum - {1'b0, size}) : sum[DimW-1:0];
    dn  = (up == '0) ? '0 : DimW'(size - up);
    if (up <= dn) return {1'b0, up[MoveW-1:0]};
    return {1'b1, dn[MoveW-1:0]};
  endfunction

  assign rows_eff = trg_pkg::eff_dim(grid_rows_i, DimCap);
  assign cols_eff = trg_pkg::eff_dim(grid_cols_i, DimCap);
  assign total_w  = (2*DimW)'(rows_eff) * (2*DimW)'(cols_eff);
  assign bad_w    = ((2*DimW)'(in_req_i.source_node) >= total_w) ||
                    ((2*DimW)'(in_req_i.dest_node) >= total_w);

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Restoring divide by cols, one quotient bit per cycle for both nodes
  assign s_trial  = {srem_q, sdiv_q[NodeW-1]};
  assign d_trial  = {drem_q, ddiv_q[NodeW-1]};
  assign s_ge     = s_trial >= cols_q;
  assign d_ge     = d_trial >= cols_q;
  assign s_rem_nx = s_ge ? CoordW'(s_trial - cols_q) : s_trial[CoordW-1:0];
  assign d_rem_nx = d_ge ? CoordW'(d_trial - cols_q) : d_trial[CoordW-1:0];

  assign col_plan = plan_dim(srem_q, drem_q, cols_q);
  assign row_plan = plan_dim(sdiv_q[CoordW-1:0], ddiv_q[CoordW-1:0], rows_q);

  assign cmd_valid_o = (state_q == ST_PUSH);
  always_comb begin
    cmd_o          = '0;
    cmd_o.bad      = bad_q;
    cmd_o.src_node = src_q;
    cmd_o.cur_row  = sdiv_q[CoordW-1:0];
    cmd_o.cur_col  = srem_q;
    cmd_o.col_cnt  = col_plan[MoveW-1:0];
    cmd_o.col_down = col_plan[MoveW];
    cmd_o.row_cnt  = row_plan[MoveW-1:0];
    cmd_o.row_down = row_plan[MoveW];
    cmd_o.rows     = rows_q;
    cmd_o.cols     = cols_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          step_q <= '0;
          if (in_valid_i) begin
            state_q <= bad_w ? ST_PUSH : ST_DIVIDE;
          end
        end
        ST_DIVIDE: begin
          step_q <= step_q + StepW'(1);
          if (step_q == StepW'(NodeW - 1)) begin
            state_q <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (cmd_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      src_q  <= in_req_i.source_node;
      sdiv_q <= in_req_i.source_node;
      ddiv_q <= in_req_i.dest_node;
      srem_q <= '0;
      drem_q <= '0;
      rows_q <= rows_eff;
      cols_q <= cols_eff;
      bad_q  <= bad_w;
    end else if (state_q == ST_DIVIDE) begin
      sdiv_q <= {sdiv_q[NodeW-2:0], s_ge};
      ddiv_q <= {ddiv_q[NodeW-2:0], d_ge};
      srem_q <= s_rem_nx;
      drem_q <= d_rem_nx;
    end
  end

  // Only in-grid requests go through the divider
  a_divide_good: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVIDE) |-> !bad_q)
    else $error("divider running on a bad request");

  // Remainders must land inside the column range
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PUSH && !bad_q) |->
      ({1'b0, srem_q} < cols_q) && ({1'b0, drem_q} < cols_q))
    else $error("column remainder out of range");

endmodule

`default_nettype wire

>>> hdl/trg_queue.sv
`default_nettype none

module trg_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire trg_pkg::trg_cmd_t in_cmd_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output trg_pkg::trg_cmd_t      out_cmd_o
);

  localparam int Depth  = trg_pkg::QUEUE_DEPTH;
  localparam int PtrW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CountW = $clog2(Depth + 1);

  trg_pkg::trg_cmd_t   mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CountW-1:0]   count_q;
  logic                push, pop;

  assign in_ready_o  = (count_q != CountW'(Depth));
  assign out_valid_o = (count_q != '0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_cmd_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) count_q <= count_q + CountW'(1);
      else if (pop && !push) count_q <= count_q - CountW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_cmd_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(Depth))
    else $error("queue count above depth");

endmodule

`default_nettype wire

>>> hdl/trg_back.sv
`default_nettype none

module trg_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cmd_valid_i,
  output logic                   cmd_ready_o,
  input  wire trg_pkg::trg_cmd_t cmd_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output trg_pkg::trg_hop_t      out_hop_o
);

  localparam int NodeW   = trg_pkg::NodeW;
  localparam int DimW    = trg_pkg::DimW;
  localparam int CoordW  = trg_pkg::CoordW;
  localparam int MoveW   = trg_pkg::MoveW;
  localparam int HopIdxW = trg_pkg::HopIdxW;
  localparam int ProdW   = CoordW + DimW;

  logic                active_q;
  logic                bad_q;
  logic [NodeW-1:0]    src_q;
  logic [CoordW-1:0]   row_q, col_q;
  logic [MoveW-1:0]    col_left_q, row_left_q;
  logic                col_down_q, row_down_q;
  logic [DimW-1:0]     rows_q, cols_q;
  logic [HopIdxW-1:0]  hop_q;
  logic                out_valid_q;
  trg_pkg::trg_hop_t   out_q;

  logic                slot_free, emit, load, last_w;
  logic [ProdW-1:0]    node_w;
  logic [CoordW-1:0]   col_nx, row_nx;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign emit        = active_q && slot_free;
  assign load        = !active_q && cmd_valid_i;
  assign cmd_ready_o = !active_q;
  assign last_w      = bad_q || ((col_left_q == '0) && (row_left_q == '0));
  assign node_w      = ProdW'(row_q) * ProdW'(cols_q) + ProdW'(col_q);

  // One wrapping step in each ring
  always_comb begin
    if (col_down_q) begin
      col_nx = (col_q == '0) ? CoordW'(cols_q - DimW'(1)) : col_q - CoordW'(1);
    end else begin
      col_nx = ({1'b0, col_q} == cols_q - DimW'(1)) ? '0 : col_q + CoordW'(1);
    end
    if (row_down_q) begin
      row_nx = (row_q == '0) ? CoordW'(rows_q - DimW'(1)) : row_q - CoordW'(1);
    end else begin
      row_nx = ({1'b0, row_q} == rows_q - DimW'(1)) ? '0 : row_q + CoordW'(1);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_hop_o   = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        active_q <= 1'b1;
      end else if (emit && last_w) begin
        active_q <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bad_q      <= cmd_i.bad;
      src_q      <= cmd_i.src_node;
      row_q      <= cmd_i.cur_row;
      col_q      <= cmd_i.cur_col;
      col_left_q <= cmd_i.col_cnt;
      row_left_q <= cmd_i.row_cnt;
      col_down_q <= cmd_i.col_down;
      row_down_q <= cmd_i.row_down;
      rows_q     <= cmd_i.rows;
      cols_q     <= cmd_i.cols;
      hop_q      <= '0;
    end else if (emit) begin
      hop_q <= hop_q + HopIdxW'(1);
      if (col_left_q != '0) begin
        col_q      <= col_nx;
        col_left_q <= col_left_q - MoveW'(1);
      end else if (row_left_q != '0) begin
        row_q      <= row_nx;
        row_left_q <= row_left_q - MoveW'(1);
      end
    end
    if (emit) begin
      out_q.hop_node    <= bad_q ? src_q : node_w[NodeW-1:0];
      out_q.hop_index   <= hop_q;
      out_q.last        <= last_w;
      out_q.bad_request <= bad_q;
    end
  end

  // Walk position stays on the grid
  a_pos_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q && !bad_q) |-> ({1'b0, col_q} < cols_q) && ({1'b0, row_q} < rows_q))
    else $error("walk left the grid");

  // Never more than half the largest ring (MAX_MOVES) in either dimension
  a_moves_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q && !bad_q) |->
      (col_left_q <= MoveW'(trg_pkg::MAX_MOVES)) && (row_left_q <= MoveW'(trg_pkg::MAX_MOVES)))
    else $error("planned moves exceed half a ring");

endmodule

`default_nettype wire

>>> bench/tb_torus_xy_route_generator_top.sv
`timescale 1ns / 1ps

module tb_torus_xy_route_generator_top;

  // Package widths used throughout the bench
  localparam int NodeW     = trg_pkg::NodeW;
  localparam int DimW      = trg_pkg::DimW;
  localparam int HopIdxW   = trg_pkg::HopIdxW;
  localparam int CfgIndexW = trg_pkg::CfgIndexW;

  // Block parameter as instantiated, and bench timing knobs
  localparam int TB_MAX_DIM     = trg_pkg::MAX_DIM_DEFAULT;
  localparam int DRAIN_CYCLES   = 40;    // front divide + queue + longest route, with margin
  localparam int HOLD_CYCLES    = 300;   // long output stall to back up the queue
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake on any channel
  localparam int PHASES         = 8;
  localparam int ITEMS_PER_PHASE = 36;
  localparam int NUM_DIRECTED   = 28;

  // Register indexes the block has no register behind; writes there must be ignored
  localparam logic [CfgIndexW-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CfgIndexW-1:0] CFG_SPARE_B = 2'd3;

  // Directed table rows: a full route checked by the predictor, a single-hop
  // result with the expected hop typed in, or a register write
  typedef enum logic [1:0] {
    ROW_ROUTE,
    ROW_SINGLE,
    ROW_CFG
  } dir_kind_e;

  typedef struct packed {
    dir_kind_e        kind;
    logic [NodeW-1:0] a;         // source node, or register index
    logic [NodeW-1:0] b;         // dest node, or register data
    logic [NodeW-1:0] exp_node;  // typed single-hop rows only
    logic             exp_bad;
  } dir_row_t;

  // DUT signals; the inputs are all known from time zero
  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  trg_pkg::trg_req_t in_req_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b1;
  trg_pkg::trg_hop_t out_hop_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic [CfgIndexW-1:0] cfg_index_i = '0;
  logic [DimW-1:0]      cfg_data_i  = '0;

  // Shadow copy of the grid registers, as last written
  logic [DimW-1:0] rows_reg = trg_pkg::GRID_DIM_RESET;
  logic [DimW-1:0] cols_reg = trg_pkg::GRID_DIM_RESET;

  // Hops still owed by the block, oldest first
  trg_pkg::trg_hop_t route_hops[$];

  int  mismatch_count = 0;
  int  reqs_sent      = 0;
  int  hops_seen      = 0;
  int  bad_seen       = 0;
  int  longest_route  = 0;
  int  run_len        = 0;
  int  cfg_writes     = 0;
  int  quiet_cycles   = 0;
  bit  idle_on        = 1'b1;
  bit  ready_hold_req = 1'b0;

  // Directed requests. Reset grid is 4x4: same node, wrap in both dimensions,
  // ties in columns and rows, out-of-grid source and dest. Then 16x16 for the
  // longest routes, zero rows (reads as 1) with oversized cols (reads as 16),
  // the transposed case, and writes to unused indexes that must change nothing.
  dir_row_t directed_rows [NUM_DIRECTED] = '{
    '{ROW_SINGLE, 8'd0,   8'd0,   8'd0,   1'b0},
    '{ROW_SINGLE, 8'd15,  8'd15,  8'd15,  1'b0},
    '{ROW_ROUTE,  8'd0,   8'd15,  8'd0,   1'b0},
    '{ROW_ROUTE,  8'd0,   8'd2,   8'd0,   1'b0},
    '{ROW_ROUTE,  8'd0,   8'd8,   8'd0,   1'b0},
    '{ROW_ROUTE,  8'd5,   8'd10,  8'd0,   1'b0},
    '{ROW_ROUTE,  8'd10,  8'd5,   8'd0,   1'b0},
    '{ROW_SINGLE, 8'd16,  8'd0,   8'd16,  1'b1},
    '{ROW_SINGLE, 8'd0,   8'd16,  8'd0,   1'b1},
    '{ROW_SINGLE, 8'd255, 8'd255, 8'd255, 1'b1},
    '{ROW_CFG,    NodeW'(trg_pkg::CFG_GRID_ROWS), 8'd16, 8'd0, 1'b0},
    '{ROW_CFG,    NodeW'(trg_pkg::CFG_GRID_COLS), 8'd16, 8'd0, 1'b0},
    '{ROW_ROUTE,  8'd0,   8'd255, 8'd0,   1'b0},
    '{ROW_ROUTE,  8'd0,   8'd136, 8'd0,   1'b0},
    '{ROW_ROUTE,  8'd255, 8'd0,   8'd0,   1'b0},
    '{ROW_SINGLE, 8'd255, 8'd255, 8'd255, 1'b0},
    '{ROW_CFG,    NodeW'(trg_pkg::CFG_GRID_ROWS), 8'd0,  8'd0, 1'b0},
    '{ROW_CFG,    NodeW'(trg_pkg::CFG_GRID_COLS), 8'd31, 8'd0, 1'b0},
    '{ROW_ROUTE,  8'd0,   8'd15,  8'd0,   1'b0},
    '{ROW_ROUTE,  8'd15,  8'd8,   8'd0,   1'b0},
    '{ROW_SINGLE, 8'd16,  8'd0,   8'd16,  1'b1},
    '{ROW_CFG,    NodeW'(trg_pkg::CFG_GRID_COLS), 8'd0,  8'd0, 1'b0},
    '{ROW_CFG,    NodeW'(trg_pkg::CFG_GRID_ROWS), 8'd20, 8'd0, 1'b0},
    '{ROW_ROUTE,  8'd0,   8'd15,  8'd0,   1'b0},
    '{ROW_SINGLE, 8'd3,   8'd16,  8'd3,   1'b1},
    '{ROW_CFG,    NodeW'(CFG_SPARE_A),   8'd7,  8'd0, 1'b0},
    '{ROW_CFG,    NodeW'(CFG_SPARE_B),   8'd9,  8'd0, 1'b0},
    '{ROW_ROUTE,  8'd3,   8'd12,  8'd0,   1'b0}
  };

  torus_xy_route_generator_top #(
    .MAX_DIM(TB_MAX_DIM)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_hop_o  (out_hop_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Route predictor
  // ---------------------------------------------------------------------------

  // Register value to grid size: zero counts as one, clamp to MAX_DIM and to 16
  function automatic int grid_dim(input logic [DimW-1:0] raw);
    int d;
    d = (raw == '0) ? 1 : int'(raw);
    if (d > TB_MAX_DIM) d = TB_MAX_DIM;
    if (d > trg_pkg::HARD_DIM_CAP) d = trg_pkg::HARD_DIM_CAP;
    return d;
  endfunction

  function automatic trg_pkg::trg_hop_t make_hop(input int node, input int idx,
                                                 input bit is_last, input bit bad);
    trg_pkg::trg_hop_t h;
    h.hop_node    = NodeW'(node);
    h.hop_index   = HopIdxW'(idx);
    h.last        = is_last;
    h.bad_request = bad;
    return h;
  endfunction

  // Append one hop to the owed list
  function automatic void owe_hop(input trg_pkg::trg_hop_t h);
    route_hops.insert(route_hops.size(), h);
  endfunction

  // Shorter way around one ring; an even split goes the increasing way
  function automatic void plan_axis(input int from, input int to, input int size,
                                    output int moves, output bit down);
    int fwd_steps;
    int dn_steps;
    fwd_steps = (to + size - from) % size;
    dn_steps  = (size - fwd_steps) % size;
    down  = (fwd_steps > dn_steps);
    moves = down ? dn_steps : fwd_steps;
  endfunction

  // Queue every hop the block owes for one request, under the current grid
  function automatic void predict_route(input logic [NodeW-1:0] src,
                                        input logic [NodeW-1:0] dst);
    int rows;
    int cols;
    int cur_r;
    int cur_c;
    int col_left;
    int row_left;
    int idx;
    bit col_down;
    bit row_down;
    rows = grid_dim(rows_reg);
    cols = grid_dim(cols_reg);
    if (int'(src) >= rows * cols || int'(dst) >= rows * cols) begin
      // Off-grid: one flagged hop carrying the source
      owe_hop(make_hop(int'(src), 0, 1'b1, 1'b1));
      return;
    end
    cur_r = int'(src) / cols;
    cur_c = int'(src) % cols;
    plan_axis(cur_c, int'(dst) % cols, cols, col_left, col_down);
    plan_axis(cur_r, int'(dst) / cols, rows, row_left, row_down);
    idx = 0;
    owe_hop(make_hop(int'(src), idx, (col_left + row_left) == 0, 1'b0));
    // X first, then Y
    while (col_left > 0) begin
      cur_c = col_down ? (cur_c + cols - 1) % cols : (cur_c + 1) % cols;
      col_left--;
      idx++;
      owe_hop(make_hop(cur_r * cols + cur_c, idx, (col_left + row_left) == 0, 1'b0));
    end
    while (row_left > 0) begin
      cur_r = row_down ? (cur_r + rows - 1) % rows : (cur_r + 1) % rows;
      row_left--;
      idx++;
      owe_hop(make_hop(cur_r * cols + cur_c, idx, row_left == 0, 1'b0));
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Request and register drivers. Handshakes are sampled right after the edge,
  // so the values seen are the ones that were present at the edge.
  // ---------------------------------------------------------------------------

  // Valid stays up on return; callers drop it only when they idle
  task automatic offer_route_req(input logic [NodeW-1:0] src, input logic [NodeW-1:0] dst,
                                 input bit typed, input trg_pkg::trg_hop_t typed_hop);
    in_req_i   <= '{source_node: src, dest_node: dst};
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (typed) owe_hop(typed_hop);
    else predict_route(src, dst);
    reqs_sent++;
  endtask

  // Only written with the block idle: all hops back, then the drain pause
  task automatic write_grid_reg(input logic [CfgIndexW-1:0] idx,
                                input logic [DimW-1:0] val);
    in_valid_i <= 1'b0;
    while (route_hops.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == trg_pkg::CFG_GRID_ROWS) rows_reg = val;
    else if (idx == trg_pkg::CFG_GRID_COLS) cols_reg = val;
    cfg_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: ready pattern in its own process. A hold request from the
  // stimulus drops ready for a long stretch; otherwise short random stalls while idling is on.
  // ---------------------------------------------------------------------------
  initial begin : ready_pattern
    int n;
    forever begin
      @(posedge clk_i);
      if (ready_hold_req) begin
        ready_hold_req = 1'b0;
        out_ready_i <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        n = $urandom_range(1, 16);
        repeat (n) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  // Hop checker and watchdog. Every accepted hop is matched against the oldest
  // owed hop; a hop with nothing owed is a failure.
  always @(posedge clk_i) begin
    trg_pkg::trg_hop_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        hops_seen++;
        if (out_hop_o.bad_request) bad_seen++;
        run_len = out_hop_o.last ? 0 : run_len + 1;
        if (int'(out_hop_o.hop_index) + 1 > longest_route)
          longest_route = int'(out_hop_o.hop_index) + 1;
        if (route_hops.size() == 0) begin
          $display("%0t: unexpected hop, expected none, actual node %0d index %0d",
                   $time, out_hop_o.hop_node, out_hop_o.hop_index);
          mismatch_count++;
        end else begin
          want = route_hops.pop_front();
          check_field("hop_node", int'(want.hop_node), int'(out_hop_o.hop_node));
          check_field("hop_index", int'(want.hop_index), int'(out_hop_o.hop_index));
          check_field("last", int'(want.last), int'(out_hop_o.last));
          check_field("bad_request", int'(want.bad_request), int'(out_hop_o.bad_request));
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: watchdog, no handshake for %0d cycles, %0d hops owed",
                   $time, quiet_cycles, route_hops.size());
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: reset, directed table, then random phases over grid settings
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int i;
    int phase;
    int pick;
    int total;
    int gap;
    logic [DimW-1:0] r_val;
    logic [DimW-1:0] c_val;
    logic [NodeW-1:0] src;
    logic [NodeW-1:0] dst;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table; single-hop rows carry their answer
    for (i = 0; i < NUM_DIRECTED; i++) begin
      unique case (directed_rows[i].kind)
        ROW_CFG: begin
          write_grid_reg(directed_rows[i].a[CfgIndexW-1:0], directed_rows[i].b[DimW-1:0]);
        end
        ROW_SINGLE: begin
          offer_route_req(directed_rows[i].a, directed_rows[i].b, 1'b1,
                          make_hop(int'(directed_rows[i].exp_node), 0, 1'b1,
                                   directed_rows[i].exp_bad));
        end
        default: begin
          offer_route_req(directed_rows[i].a, directed_rows[i].b, 1'b0, '0);
        end
      endcase
    end

    // Random phases: fixed extremes first, then random register values (0..31
    // covers the zero and oversize clamps). Last phase runs with no idling.
    for (phase = 0; phase < PHASES; phase++) begin
      unique case (phase)
        0: begin r_val = 5'd1;  c_val = 5'd1;  end
        1: begin r_val = 5'd16; c_val = 5'd16; end
        2: begin r_val = 5'd0;  c_val = 5'd31; end
        3: begin r_val = 5'd31; c_val = 5'd2;  end
        default: begin
          r_val = DimW'($urandom_range(0, 31));
          c_val = DimW'($urandom_range(0, 31));
        end
      endcase
      write_grid_reg(trg_pkg::CFG_GRID_ROWS, r_val);
      write_grid_reg(trg_pkg::CFG_GRID_COLS, c_val);
      if ($urandom_range(0, 2) == 0)
        write_grid_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                       DimW'($urandom_range(0, 31)));

      idle_on = (phase != PHASES - 1) && (phase < 2 || $urandom_range(0, 3) != 0);

      // Long output stall on the big grid while requests keep coming, so the
      // plan queue fills and in_ready_o drops
      if (phase == 1) ready_hold_req = 1'b1;

      total = grid_dim(rows_reg) * grid_dim(cols_reg);
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        // Mid-phase once: stop sending until every owed hop is back
        if (phase == 3 && i == ITEMS_PER_PHASE / 2) begin
          in_valid_i <= 1'b0;
          do @(posedge clk_i); while (route_hops.size() != 0);
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
          in_valid_i <= 1'b0;
          gap = $urandom_range(1, 16);
          repeat (gap) @(posedge clk_i);
        end
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          // mostly real routes inside the grid
          src = NodeW'($urandom_range(0, total - 1));
          dst = NodeW'($urandom_range(0, total - 1));
        end else if (pick == 7) begin
          src = NodeW'($urandom_range(0, total - 1));
          dst = src;
        end else begin
          // any 8-bit node, mostly off-grid on small grids
          src = NodeW'($urandom());
          dst = NodeW'($urandom());
        end
        offer_route_req(src, dst, 1'b0, '0);
      end
    end

    // Wind down: all hops back, then the drain pause for strays
    in_valid_i <= 1'b0;
    while (route_hops.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d route requests over %0d register writes; checked %0d hops",
             reqs_sent, cfg_writes, hops_seen);
    $display("Off-grid rejections: %0d, longest route: %0d hops", bad_seen, longest_route);
    if (mismatch_count == 0 && route_hops.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/trg_pkg.sv
hdl/trg_front.sv
hdl/trg_queue.sv
hdl/trg_back.sv
hdl/torus_xy_route_generator_top.sv
bench/tb_torus_xy_route_generator_top.sv
